>>> design/blot_pkg.sv
package blot_pkg;

    // Table size and internal arithmetic width
    localparam int MAX_BOXES_DEF = 32;
    localparam int WIDE_W        = 40;

    // Command codes carried by a request
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef logic [2:0] status_t;

    // Result status codes
    localparam status_t ST_OVERLAP  = 3'd0;
    localparam status_t ST_SEPARATE = 3'd1;
    localparam status_t ST_EMPTY    = 3'd2;
    localparam status_t ST_DONE     = 3'd3;
    localparam status_t ST_REJECT   = 3'd4;

    // 1.0 in Q16.16: a loaded box must be larger than this in w and h
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 40'sd2147483647;
    localparam logic signed [WIDE_W-1:0] S32_MIN = -40'sd2147483648;

    typedef logic signed [WIDE_W-1:0] wide_t;

    // One table entry as held in the box memory
    typedef struct packed {
        logic [14:0]        action;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] w;
        logic signed [31:0] h;
    } box_entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;
        logic    clear_count;
        logic    load_box;
        logic    walk_start;
        logic    fin_simple;
        status_t fin_status;
        logic    fin_query;
        logic    out_load;
    } blot_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] command;
        logic       load_ok;
        logic       count_zero;
        logic       walk_busy;
    } blot_stat_t;

    function automatic wide_t sext(input logic [31:0] v);
        wide_t r;
        r = {{(WIDE_W-32){v[31]}}, v};
        return r;
    endfunction

    function automatic logic [31:0] sat32(input wide_t v);
        logic [31:0] r;
        if (v > S32_MAX)
            r = S32_MAX[31:0];
        else if (v < S32_MIN)
            r = S32_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> design/blot_ram.sv
module blot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

>>> design/blot_ctrl.sv
module blot_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                res_valid,
    input  logic                res_stall,
    input  blot_pkg::blot_stat_t stat,
    output blot_pkg::blot_cmd_t  cmd
);

    import blot_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_FINAL  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;
    logic       slot_free;

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign slot_free = !res_valid_reg || !res_stall;

    // Sequence one request through decode, a table walk for a non-empty query, and result
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_RESULT;
                unique case (stat.command)
                    CMD_CLEAR:
                    begin
                        cmd.clear_count = 1'b1;
                        cmd.fin_simple  = 1'b1;
                        cmd.fin_status  = ST_DONE;
                    end
                    CMD_LOAD:
                    begin
                        cmd.fin_simple = 1'b1;
                        if (stat.load_ok)
                        begin
                            cmd.load_box   = 1'b1;
                            cmd.fin_status = ST_DONE;
                        end
                        else
                            cmd.fin_status = ST_REJECT;
                    end
                    CMD_QUERY:
                    begin
                        if (stat.count_zero)
                        begin
                            cmd.fin_simple = 1'b1;
                            cmd.fin_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    default:
                    begin
                        cmd.fin_simple = 1'b1;
                        cmd.fin_status = ST_REJECT;
                    end
                endcase
            end
            S_WALK:
            begin
                if (!stat.walk_busy)
                    state_next = S_FINAL;
            end
            S_FINAL:
            begin
                cmd.fin_query = 1'b1;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold the result valid until it is taken
    always_comb
    begin
        if (cmd.out_load)
            res_valid_next = 1'b1;
        else
            res_valid_next = res_valid_reg && res_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

>>> design/blot_dp.sv
module blot_dp #(
    parameter int MAX_BOXES = blot_pkg::MAX_BOXES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  blot_pkg::blot_cmd_t                    cmd,
    output blot_pkg::blot_stat_t                   stat,
    // request fields
    input  logic [1:0]                             command,
    input  logic [14:0]                            action,
    input  logic signed [31:0]                     rect_x,
    input  logic signed [31:0]                     rect_y,
    input  logic signed [31:0]                     rect_w,
    input  logic signed [31:0]                     rect_h,
    input  logic signed [31:0]                     pos_x,
    input  logic signed [31:0]                     pos_y,
    input  logic                                   face_left,
    // box memory
    output logic                                   ram_we,
    output logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] ram_waddr,
    output blot_pkg::box_entry_t                   ram_wdata,
    output logic                                   ram_re,
    output logic [((MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1)-1:0] ram_raddr,
    input  blot_pkg::box_entry_t                   ram_rdata,
    // result fields
    output blot_pkg::status_t                      status,
    output logic [14:0]                            action_used,
    output logic signed [31:0]                     out_x,
    output logic signed [31:0]                     out_y,
    output logic signed [31:0]                     out_w,
    output logic signed [31:0]                     out_h,
    output logic [$clog2(MAX_BOXES+1)-1:0]         entry_count
);

    import blot_pkg::*;

    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);

    // Captured request
    logic [1:0]         cmd_reg;
    logic [14:0]        act_reg;
    logic signed [31:0] rx_reg, ry_reg, rw_reg, rh_reg;
    logic signed [31:0] px_reg, py_reg;
    logic               face_reg;
    wide_t              br_reg, bt_reg;

    // Table fill and walk control
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               issuing_reg, v1_reg, v2_reg;

    // Moved box stage
    wide_t              s1_ax_reg, s1_ay_reg, s1_r_reg, s1_t_reg;
    logic signed [31:0] s1_w_reg, s1_h_reg;
    logic [14:0]        s1_act_reg;

    // Union and first hit
    logic               first_reg, hit_reg;
    wide_t              ul_reg, ub_reg, ur_reg, ut_reg;
    wide_t              hx_reg, hy_reg;
    logic signed [31:0] hw_reg, hh_reg;
    logic [14:0]        hact_reg;

    // Finished result and output register
    status_t            fin_status_reg;
    logic [14:0]        fin_act_reg;
    logic [31:0]        fin_x_reg, fin_y_reg, fin_w_reg, fin_h_reg;
    status_t            out_status_reg;
    logic [14:0]        out_act_reg;
    logic [31:0]        out_x_reg, out_y_reg, out_w_reg, out_h_reg;
    logic [CNT_W-1:0]   out_count_reg;

    wide_t              lx, ly, lw, lh, px, py;
    wide_t              bl, bb;
    logic               overlap;

    // Status to the controller
    assign stat.command    = cmd_reg;
    assign stat.load_ok    = (rw_reg > ONE_Q16) && (rh_reg > ONE_Q16)
                             && (count_reg < CNT_W'(MAX_BOXES));
    assign stat.count_zero = (count_reg == '0);
    assign stat.walk_busy  = issuing_reg || v1_reg || v2_reg;

    // Table write on load, table read during the walk
    assign ram_we           = cmd.load_box;
    assign ram_waddr        = count_reg[ADDR_W-1:0];
    assign ram_wdata.action = act_reg;
    assign ram_wdata.x      = rx_reg;
    assign ram_wdata.y      = ry_reg;
    assign ram_wdata.w      = rw_reg;
    assign ram_wdata.h      = rh_reg;
    assign ram_re           = issuing_reg;
    assign ram_raddr        = idx_reg[ADDR_W-1:0];

    assign lx = sext(ram_rdata.x);
    assign ly = sext(ram_rdata.y);
    assign lw = sext(ram_rdata.w);
    assign lh = sext(ram_rdata.h);
    assign px = sext(px_reg);
    assign py = sext(py_reg);
    assign bl = sext(rx_reg);
    assign bb = sext(ry_reg);

    // Strict overlap of the moved box with the body box
    assign overlap = (s1_r_reg > bl) && (s1_ax_reg < br_reg)
                     && (s1_t_reg > bb) && (s1_ay_reg < bt_reg);

    // Capture the request and the body box edges
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= command;
            act_reg  <= action;
            rx_reg   <= rect_x;
            ry_reg   <= rect_y;
            rw_reg   <= rect_w;
            rh_reg   <= rect_h;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            face_reg <= face_left;
            br_reg   <= sext(rect_x) + sext(rect_w);
            bt_reg   <= sext(rect_y) + sext(rect_h);
        end
    end

    // Count boxes, issue table reads and track the read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            idx_reg     <= '0;
            issuing_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear_count)
                count_reg <= '0;
            else if (cmd.load_box)
                count_reg <= count_reg + 1'b1;

            if (cmd.walk_start)
            begin
                idx_reg     <= '0;
                issuing_reg <= 1'b1;
            end
            else if (issuing_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg + 1'b1 == count_reg)
                    issuing_reg <= 1'b0;
            end

            v1_reg <= issuing_reg;
            v2_reg <= v1_reg;
        end
    end

    // Move the read box to the origin, mirrored when facing right
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            if (face_reg)
            begin
                s1_ax_reg <= px + lx;
                s1_r_reg  <= px + lx + lw;
            end
            else
            begin
                s1_ax_reg <= px - lx - lw;
                s1_r_reg  <= px - lx;
            end
            s1_ay_reg  <= py + ly;
            s1_t_reg   <= py + ly + lh;
            s1_w_reg   <= ram_rdata.w;
            s1_h_reg   <= ram_rdata.h;
            s1_act_reg <= ram_rdata.action;
        end
    end

    // Walk flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            hit_reg   <= 1'b0;
        end
        else if (cmd.walk_start)
        begin
            first_reg <= 1'b1;
            hit_reg   <= 1'b0;
        end
        else if (v2_reg)
        begin
            first_reg <= 1'b0;
            if (overlap)
                hit_reg <= 1'b1;
        end
    end

    // Grow the union and keep the first hit
    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            if (first_reg || s1_ax_reg < ul_reg)
                ul_reg <= s1_ax_reg;
            if (first_reg || s1_ay_reg < ub_reg)
                ub_reg <= s1_ay_reg;
            if (first_reg || s1_r_reg > ur_reg)
                ur_reg <= s1_r_reg;
            if (first_reg || s1_t_reg > ut_reg)
                ut_reg <= s1_t_reg;
            if (!hit_reg && overlap)
            begin
                hx_reg   <= s1_ax_reg;
                hy_reg   <= s1_ay_reg;
                hw_reg   <= s1_w_reg;
                hh_reg   <= s1_h_reg;
                hact_reg <= s1_act_reg;
            end
        end
    end

    // Form the finished result
    always_ff @(posedge clk)
    begin
        if (cmd.fin_simple)
        begin
            fin_status_reg <= cmd.fin_status;
            fin_act_reg    <= '0;
            fin_x_reg      <= '0;
            fin_y_reg      <= '0;
            fin_w_reg      <= '0;
            fin_h_reg      <= '0;
        end
        else if (cmd.fin_query)
        begin
            if (hit_reg)
            begin
                fin_status_reg <= ST_OVERLAP;
                fin_act_reg    <= hact_reg;
                fin_x_reg      <= sat32(hx_reg);
                fin_y_reg      <= sat32(hy_reg);
                fin_w_reg      <= hw_reg;
                fin_h_reg      <= hh_reg;
            end
            else
            begin
                fin_status_reg <= ST_SEPARATE;
                fin_act_reg    <= '0;
                fin_x_reg      <= sat32(ul_reg);
                fin_y_reg      <= sat32(ub_reg);
                fin_w_reg      <= sat32(ur_reg - ul_reg);
                fin_h_reg      <= sat32(ut_reg - ub_reg);
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= fin_status_reg;
            out_act_reg    <= fin_act_reg;
            out_x_reg      <= fin_x_reg;
            out_y_reg      <= fin_y_reg;
            out_w_reg      <= fin_w_reg;
            out_h_reg      <= fin_h_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign status      = out_status_reg;
    assign action_used = out_act_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_w       = out_w_reg;
    assign out_h       = out_h_reg;
    assign entry_count = out_count_reg;

endmodule

>>> design/box_list_overlap_test.sv
// Attack-box overlap tester. A request either clears the box table, loads one
// box (taken only when its width and height exceed 1.0 and the table has room)
// or queries the table against a body box at a given origin and facing. The
// result of a query is the first overlapping box with its action key, or the
// saturated union box of all held boxes; an empty table answers with the
// empty-table status.
// Every request gives exactly one result, and entry_count shows the table fill
// after it. A query reads the table memory one box per cycle through a
// two-stage move-and-compare pipeline. One request is in work at a time; a
// finished result waits in the output register while the next request is
// accepted.
module box_list_overlap_test #(
    parameter int MAX_BOXES = blot_pkg::MAX_BOXES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [1:0]                     command,
    input  logic [14:0]                    action,
    input  logic signed [31:0]             rect_x,
    input  logic signed [31:0]             rect_y,
    input  logic signed [31:0]             rect_w,
    input  logic signed [31:0]             rect_h,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic                           face_left,
    output logic                           res_valid,
    input  logic                           res_stall,
    output blot_pkg::status_t              status,
    output logic [14:0]                    action_used,
    output logic signed [31:0]             out_x,
    output logic signed [31:0]             out_y,
    output logic signed [31:0]             out_w,
    output logic signed [31:0]             out_h,
    output logic [$clog2(MAX_BOXES+1)-1:0] entry_count
);

    import blot_pkg::*;

    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    blot_cmd_t   cmd;
    blot_stat_t  stat;
    logic        ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    box_entry_t  ram_wdata, ram_rdata;

    blot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    blot_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .command     (command),
        .action      (action),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_w      (rect_w),
        .rect_h      (rect_h),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .face_left   (face_left),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .status      (status),
        .action_used (action_used),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_w       (out_w),
        .out_h       (out_h),
        .entry_count (entry_count)
    );

    blot_ram #(
        .WIDTH ($bits(box_entry_t)),
        .DEPTH (MAX_BOXES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

>>> design/blot_checker.sv
module blot_checker #(
    parameter int MAX_BOXES = blot_pkg::MAX_BOXES_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           res_valid,
    input logic                           res_stall,
    input blot_pkg::status_t              status,
    input logic [14:0]                    action_used,
    input logic signed [31:0]             out_x,
    input logic signed [31:0]             out_w,
    input logic [$clog2(MAX_BOXES+1)-1:0] entry_count
);

    import blot_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status)
            && $stable(out_x) && $stable(entry_count))
        else $error("stalled result changed");

    // Never report more boxes than the table holds
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> entry_count <= CNT_W'(MAX_BOXES))
        else $error("entry count above table size");

    // An empty table answers with zeroed fields
    a_empty_table: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_EMPTY |->
            entry_count == '0 && action_used == '0 && out_x == '0)
        else $error("empty-table answer with non-zero fields");

    // A query result needs boxes in the table
    a_query_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_OVERLAP || status == ST_SEPARATE) |->
            entry_count != '0)
        else $error("query result with empty table");

    // Table commands carry no box
    a_table_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ST_DONE || status == ST_REJECT) |->
            action_used == '0 && out_w == '0)
        else $error("table command result carries box fields");

endmodule

bind box_list_overlap_test blot_checker #(
    .MAX_BOXES (MAX_BOXES)
) u_blot_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .action_used (action_used),
    .out_x       (out_x),
    .out_w       (out_w),
    .entry_count (entry_count)
);
